FILE: rtl/psob_pkg.sv
// ============================================================================
// psob_pkg
// Shared types, constants and the sine table generator for the polyphonic
// sine oscillator bank.
// ============================================================================
`default_nettype none

package psob_pkg;

  // Default sizing
  localparam int PSOB_VOICES       = 64;
  localparam int PSOB_PHASE_BITS   = 32;
  localparam int PSOB_SINE_ENTRIES = 1024;

  // Field widths
  localparam int FREQ_W   = 23;
  localparam int GAIN_W   = 16;
  localparam int SINE_W   = 16;
  localparam int SAMPLE_W = 22;
  localparam int HZ_W     = 40;
  localparam int HZ_HALF  = 20;

  // Increment = (frequency * hz_to_step) >> INC_SHIFT
  localparam int INC_SHIFT = 24;
  localparam int FULL_W    = FREQ_W + HZ_W;

  // Shared multiplier operand widths (one spare sign bit each)
  localparam int MUL_A_W = FREQ_W + 1;
  localparam int MUL_B_W = HZ_HALF + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int TRIG_P_W = FREQ_W + HZ_HALF;
  localparam int TICK_P_W = 32;

  // Reset value of hz_to_step: 2^48 / 44100
  localparam logic [HZ_W-1:0] HZ_RESET = 40'd6382652533;

  // Output rounding and saturation
  localparam int ROUND_HALF = 16384;
  localparam int OUT_SHIFT  = 15;
  localparam int OUT_MAX    = 2097151;
  localparam int OUT_MIN    = -2097152;

  // Command and status codes
  localparam logic CMD_TRIGGER = 1'b0;
  localparam logic CMD_TICK    = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_TRIG_LO,
    S_TRIG_HI,
    S_TRIG_WR,
    S_TICK,
    S_DONE
  } psob_state_t;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // One table entry from a 32-bit turn: fold to the first quadrant, odd
  // Taylor series to x^13 in Q30, round to Q15, restore sign.
  function automatic logic signed [SINE_W-1:0] psob_sine_entry(input logic [63:0] turn);
    logic [1:0]         quad;
    logic [63:0]        r;
    logic [63:0]        t;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    quad = turn[31:30];
    r    = {34'd0, turn[29:0]};
    t    = quad[0] ? (64'h40000000 - r) : r;
    x    = (t * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + signed'(term);
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32767) begin
      sum = 64'sd32767;
    end
    if (quad[1]) begin
      sum = -sum;
    end
    return sum[SINE_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/psob_mul.sv
// ============================================================================
// psob_mul
// Shared signed multiplier with a registered product. Serves both the
// increment partial products and the per-voice gain * sine products.
// ============================================================================
`default_nettype none

module psob_mul
  import psob_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic signed [MUL_A_W-1:0] op_a,
  input  wire logic signed [MUL_B_W-1:0] op_b,
  output logic signed [MUL_P_W-1:0]      prod_r
);

  // One multiply per cycle, product registered
  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
  end

endmodule

`default_nettype wire

FILE: rtl/psob_sine_rom.sv
// ============================================================================
// psob_sine_rom
// Sine lookup ROM, Q1.15 entries built at elaboration, registered read.
// ============================================================================
`default_nettype none

module psob_sine_rom
  import psob_pkg::*;
#(
  parameter int SINE_ENTRIES = PSOB_SINE_ENTRIES
) (
  input  wire logic                              clk,
  input  wire logic [$clog2(SINE_ENTRIES)-1:0]   rd_idx,
  output logic signed [SINE_W-1:0]               rd_data_r
);

  logic signed [SINE_W-1:0] rom_tab [SINE_ENTRIES];

  // Entry k holds sin(2*pi*k/SINE_ENTRIES)
  for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_tab
    localparam logic [63:0] TURN_K = (64'(k) << 32) / SINE_ENTRIES;
    assign rom_tab[k] = psob_sine_entry(TURN_K);
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data_r <= rom_tab[rd_idx];
  end

endmodule

`default_nettype wire

FILE: rtl/psob_voice_ram.sv
// ============================================================================
// psob_voice_ram
// Per-voice phase, increment and gain storage. One read address and one
// write address per cycle, read data registered.
// ============================================================================
`default_nettype none

module psob_voice_ram
  import psob_pkg::*;
#(
  parameter int VOICES     = PSOB_VOICES,
  parameter int PHASE_BITS = PSOB_PHASE_BITS,
  localparam int VIDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  wire logic                   clk,
  input  wire logic [VIDX_W-1:0]      rd_addr,
  input  wire logic                   wr_voice_en,
  input  wire logic                   wr_phase_en,
  input  wire logic [VIDX_W-1:0]      wr_addr,
  input  wire logic [PHASE_BITS-1:0]  wr_phase,
  input  wire logic [PHASE_BITS-1:0]  wr_inc,
  input  wire logic [GAIN_W-1:0]      wr_gain,
  output logic [PHASE_BITS-1:0]       rd_phase_r,
  output logic [PHASE_BITS-1:0]       rd_inc_r,
  output logic [GAIN_W-1:0]           rd_gain_r
);

  logic [PHASE_BITS-1:0] phase_mem [VOICES];
  logic [PHASE_BITS-1:0] inc_mem   [VOICES];
  logic [GAIN_W-1:0]     gain_mem  [VOICES];

  // Write port: a new voice writes all fields, a tick updates the phase
  always_ff @(posedge clk) begin
    if (wr_voice_en || wr_phase_en) begin
      phase_mem[wr_addr] <= wr_phase;
    end
    if (wr_voice_en) begin
      inc_mem[wr_addr]  <= wr_inc;
      gain_mem[wr_addr] <= wr_gain;
    end
  end

  // Read port
  always_ff @(posedge clk) begin
    rd_phase_r <= phase_mem[rd_addr];
    rd_inc_r   <= inc_mem[rd_addr];
    rd_gain_r  <= gain_mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/polyphonic_sine_oscillator_bank_core.sv
// ============================================================================
// polyphonic_sine_oscillator_bank_core
// Bank of DDS sine voices. Trigger claims the next free voice; tick sums
// gain * sine over all claimed voices and advances their phases.
// ============================================================================
//
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_ready   in_command, in_frequency, in_amplitude
// out      out  out_valid / out_ready out_status, out_sample
// cfg      in   cfg_wr_en             cfg_wr_data (hz_to_step)
//
// Trigger: two partial products on the shared multiplier, then one add and
//   voice write; a trigger on a full bank goes straight to the final state.
// Tick: one voice per cycle streams through voice RAM read, sine ROM read,
//   shared multiplier and accumulator.
// Voices are claimed in order, so a fill count marks the active set; reset
//   clears it at once and needs no clearing pass.
// in_ready is low while an item is in flight; a result waits in the output
//   register while the next item is accepted and worked on. If that result
//   is still held, the sequencer waits in its final state.
// ============================================================================
`default_nettype none

module polyphonic_sine_oscillator_bank_core
  import psob_pkg::*;
#(
  parameter int VOICES       = PSOB_VOICES,
  parameter int PHASE_BITS   = PSOB_PHASE_BITS,
  parameter int SINE_ENTRIES = PSOB_SINE_ENTRIES
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_command,
  input  wire logic [FREQ_W-1:0]          in_frequency,
  input  wire logic signed [GAIN_W-1:0]   in_amplitude,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_status,
  output logic signed [SAMPLE_W-1:0]      out_sample,
  input  wire logic                       cfg_wr_en,
  input  wire logic [HZ_W-1:0]            cfg_wr_data
);

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W  = $clog2(VOICES + 1);
  localparam int SIDX_W = $clog2(SINE_ENTRIES);
  localparam int IDX_PW = PHASE_BITS + SIDX_W;
  localparam int ACC_W  = TICK_P_W + $clog2(VOICES + 1);
  localparam int SUM_W  = ACC_W + 1;

  psob_state_t state_r, state_nxt;

  logic [HZ_W-1:0]          hz_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         iss_r;
  logic [3:0]               v_r;
  logic [VIDX_W-1:0]        a1_r;
  logic [SIDX_W-1:0]        idx_r;
  logic [GAIN_W-1:0]        g1_r;
  logic [GAIN_W-1:0]        g2_r;
  logic [TRIG_P_W-1:0]      lo_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     cmd_r;
  logic [FREQ_W-1:0]        freq_r;
  logic [GAIN_W-1:0]        amp_r;
  logic                     full_r;
  logic                     out_valid_r;
  logic                     out_status_r;
  logic [SAMPLE_W-1:0]      out_sample_r;

  logic                     in_xfer;
  logic                     bank_full;
  logic                     issue;
  logic                     voice_we;
  logic                     slot_free;
  logic [PHASE_BITS-1:0]    rd_phase;
  logic [PHASE_BITS-1:0]    rd_inc;
  logic [GAIN_W-1:0]        rd_gain;
  logic signed [SINE_W-1:0] sine_q;
  logic [IDX_PW-1:0]        idx_prod;
  logic [FULL_W-1:0]        full_prod;
  logic [PHASE_BITS-1:0]    new_inc;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [SUM_W-1:0]  rnd_sum;
  logic signed [SUM_W-1:0]  rnd_q;
  logic [SAMPLE_W-1:0]      sat_sample;

  assign in_ready   = (state_r == S_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign bank_full  = (cnt_r == CNT_W'(VOICES));
  assign issue      = (state_r == S_TICK) && (iss_r < cnt_r);
  assign voice_we   = (state_r == S_TRIG_WR);
  assign slot_free  = !out_valid_r || out_ready;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_command == CMD_TICK) begin
            state_nxt = S_TICK;
          end else if (bank_full) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_TRIG_LO;
          end
        end
      end
      S_TRIG_LO: state_nxt = S_TRIG_HI;
      S_TRIG_HI: state_nxt = S_TRIG_WR;
      S_TRIG_WR: state_nxt = S_DONE;
      S_TICK: begin
        if (!issue && (v_r == 4'd0)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hz_r <= HZ_RESET;
    end else if (cfg_wr_en) begin
      hz_r <= cfg_wr_data;
    end
  end

  // Fill count, issue counter and stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      iss_r <= '0;
      v_r   <= '0;
    end else begin
      if (voice_we) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (in_xfer) begin
        iss_r <= '0;
      end else if (issue) begin
        iss_r <= iss_r + CNT_W'(1);
      end
      v_r <= {v_r[2:0], issue};
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r  <= in_command;
      freq_r <= in_frequency;
      amp_r  <= in_amplitude;
      full_r <= (in_command == CMD_TRIGGER) && bank_full;
    end
  end

  // Voice storage
  psob_voice_ram #(
    .VOICES     (VOICES),
    .PHASE_BITS (PHASE_BITS)
  ) u_ram (
    .clk         (clk),
    .rd_addr     (iss_r[VIDX_W-1:0]),
    .wr_voice_en (voice_we),
    .wr_phase_en (v_r[0]),
    .wr_addr     (voice_we ? cnt_r[VIDX_W-1:0] : a1_r),
    .wr_phase    (voice_we ? '0 : rd_phase + rd_inc),
    .wr_inc      (new_inc),
    .wr_gain     (amp_r),
    .rd_phase_r  (rd_phase),
    .rd_inc_r    (rd_inc),
    .rd_gain_r   (rd_gain)
  );

  // Tick pipeline: phase to table index, gain delay
  assign idx_prod = IDX_PW'(rd_phase) * IDX_PW'(SINE_ENTRIES);

  always_ff @(posedge clk) begin
    a1_r  <= iss_r[VIDX_W-1:0];
    idx_r <= idx_prod[PHASE_BITS +: SIDX_W];
    g1_r  <= rd_gain;
    g2_r  <= g1_r;
  end

  psob_sine_rom #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_rom (
    .clk       (clk),
    .rd_idx    (idx_r),
    .rd_data_r (sine_q)
  );

  // Shared multiplier operands
  always_comb begin
    mul_a = MUL_A_W'(signed'(g2_r));
    mul_b = MUL_B_W'(sine_q);
    if (state_r == S_TRIG_LO) begin
      mul_a = signed'({1'b0, freq_r});
      mul_b = signed'({1'b0, hz_r[HZ_HALF-1:0]});
    end else if (state_r == S_TRIG_HI) begin
      mul_a = signed'({1'b0, freq_r});
      mul_b = signed'({1'b0, hz_r[HZ_W-1:HZ_HALF]});
    end
  end

  psob_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_p)
  );

  // Increment from the two partial products
  always_ff @(posedge clk) begin
    if (state_r == S_TRIG_HI) begin
      lo_r <= mul_p[TRIG_P_W-1:0];
    end
  end

  assign full_prod = FULL_W'(lo_r) + (FULL_W'(mul_p[TRIG_P_W-1:0]) << HZ_HALF);
  assign new_inc   = full_prod[INC_SHIFT +: PHASE_BITS];

  // Accumulator
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      acc_r <= '0;
    end else if (v_r[3]) begin
      acc_r <= acc_r + ACC_W'(signed'(mul_p[TICK_P_W-1:0]));
    end
  end

  // Round once, then saturate
  assign rnd_sum = SUM_W'(acc_r) + SUM_W'(ROUND_HALF);
  assign rnd_q   = rnd_sum >>> OUT_SHIFT;

  always_comb begin
    if (rnd_q > SUM_W'(OUT_MAX)) begin
      sat_sample = SAMPLE_W'(OUT_MAX);
    end else if (rnd_q < SUM_W'(OUT_MIN)) begin
      sat_sample = SAMPLE_W'(OUT_MIN);
    end else begin
      sat_sample = rnd_q[SAMPLE_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && slot_free) begin
      out_status_r <= full_r ? STATUS_FULL : STATUS_OK;
      out_sample_r <= (cmd_r == CMD_TICK) ? sat_sample : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_sample = out_sample_r;

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(VOICES))
    else $error("fill count beyond bank size");

  a_iss_range: assert property (@(posedge clk) disable iff (!rst_n)
    iss_r <= cnt_r)
    else $error("tick issued past the active voices");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (v_r == 4'd0))
    else $error("tick pipeline busy while idle");

  a_claim_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TRIG_WR) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("voice claim did not advance the fill count");

  a_full_no_claim: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_command == CMD_TRIGGER) && bank_full) |=> (state_r == S_DONE))
    else $error("trigger on a full bank started a claim");

endmodule

`default_nettype wire

FILE: verif/polyphonic_sine_oscillator_bank_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// polyphonic_sine_oscillator_bank_core_tb
// Self-checking bench for the sine oscillator bank. A cycle-free model of the
// voice bank (own sine table, voice slots, rate register) predicts one output
// per accepted command; a receiver process checks every output transfer in
// order. Directed tests cover the empty bank, rate extremes, wrapped and zero
// increments and a full bank; random phases vary sender and receiver idling.
// ============================================================================

module polyphonic_sine_oscillator_bank_core_tb;
  import psob_pkg::*;

  // Run control
  localparam int STALL_LIMIT   = 5000;  // cycles with no transfer on either side
  localparam int END_WAIT      = 200;
  localparam int PRESSURE_HOLD = 400;
  localparam int BATCH_ITEMS   = 40;
  localparam int PHASE_ITEMS   = 320;
  localparam int TRIGGER_PCT   = 20;
  localparam int MAX_REPORTS   = 30;
  localparam logic [HZ_W-1:0]   RATE_MAX = {HZ_W{1'b1}};
  localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

  typedef struct packed {
    logic                       status;
    logic signed [SAMPLE_W-1:0] sample;
  } bank_output_t;

  // DUT signals
  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       in_valid     = 1'b0;
  logic                       in_ready;
  logic                       in_command   = CMD_TICK;
  logic [FREQ_W-1:0]          in_frequency = '0;
  logic signed [GAIN_W-1:0]   in_amplitude = '0;
  logic                       out_valid;
  logic                       out_ready    = 1'b0;
  logic                       out_status;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       cfg_wr_en    = 1'b0;
  logic [HZ_W-1:0]            cfg_wr_data  = '0;

  // Bank model state
  int                           sine_lut [PSOB_SINE_ENTRIES];
  logic [HZ_W-1:0]              rate_model;
  int                           voices_used;
  logic [PSOB_PHASE_BITS-1:0]   voice_phase_m [PSOB_VOICES];
  logic [PSOB_PHASE_BITS-1:0]   voice_step_m  [PSOB_VOICES];
  logic signed [GAIN_W-1:0]     voice_gain_m  [PSOB_VOICES];
  bank_output_t                 pending_outputs [$];

  // Shared bench controls
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off_left  = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  polyphonic_sine_oscillator_bank_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_frequency (in_frequency),
    .in_amplitude (in_amplitude),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_sample   (out_sample),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  // Q1.15 sine of table entry k: quadrant fold, Q30 Taylor series to x^13
  function automatic int sine_point(input int k);
    logic [63:0] turn;
    logic [63:0] rem;
    logic [63:0] t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [1:0]  quad;
    longint      acc;
    bit          negate;
    turn   = (64'(k) << 32) / PSOB_SINE_ENTRIES;
    quad   = turn[31:30];
    rem    = {34'd0, turn[29:0]};
    t      = quad[0] ? ((64'd1 << 30) - rem) : rem;
    x      = (t * HALF_PI_Q30) >> 30;
    x2     = (x * x) >> 30;
    term   = x;
    acc    = longint'(x);
    negate = 1'b1;
    for (int n = 3; n <= 13; n += 2) begin
      term = ((term * x2) >> 30) / 64'((n - 1) * n);
      if (negate) begin
        acc -= longint'(term);
      end else begin
        acc += longint'(term);
      end
      negate = !negate;
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 16384) >>> 15;
    if (acc > 32767) begin
      acc = 32767;
    end
    return quad[1] ? -int'(acc) : int'(acc);
  endfunction

  // Apply one accepted command to the bank model and queue its output
  function automatic void predict_bank_output(input logic cmd,
                                              input logic [FREQ_W-1:0] freq,
                                              input logic signed [GAIN_W-1:0] amp);
    bank_output_t res;
    logic [63:0]  prod;
    logic [63:0]  lut_idx;
    longint       acc;
    res.status = STATUS_OK;
    res.sample = '0;
    if (cmd == CMD_TRIGGER) begin
      if (voices_used < PSOB_VOICES) begin
        prod = 64'(freq) * 64'(rate_model);
        voice_step_m[voices_used]  = prod[INC_SHIFT +: PSOB_PHASE_BITS];
        voice_gain_m[voices_used]  = amp;
        voice_phase_m[voices_used] = '0;
        voices_used++;
      end else begin
        res.status = STATUS_FULL;
      end
    end else begin
      acc = 0;
      for (int v = 0; v < voices_used; v++) begin
        lut_idx = (64'(voice_phase_m[v]) * PSOB_SINE_ENTRIES) >> PSOB_PHASE_BITS;
        acc += longint'(voice_gain_m[v]) * longint'(sine_lut[lut_idx]);
        voice_phase_m[v] = voice_phase_m[v] + voice_step_m[v];
      end
      acc = (acc + ROUND_HALF) >>> OUT_SHIFT;
      if (acc > OUT_MAX) begin
        acc = OUT_MAX;
      end
      if (acc < OUT_MIN) begin
        acc = OUT_MIN;
      end
      res.sample = acc[SAMPLE_W-1:0];
    end
    pending_outputs.push_back(res);
  endfunction

  // --------------------------------------------------------------------------
  // Driving and checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // One input transfer; the model is updated at the accepting edge
  task automatic send_item(input logic cmd, input logic [FREQ_W-1:0] freq,
                           input logic signed [GAIN_W-1:0] amp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_frequency <= freq;
    in_amplitude <= amp;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    predict_bank_output(cmd, freq, amp);
  endtask

  // Drop valid and wait for every predicted output to be taken
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Rate register write, only with the bank idle
  task automatic write_rate(input logic [HZ_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    rate_model = value;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_random_item(input int trigger_pct);
    logic                     cmd;
    logic [FREQ_W-1:0]        freq;
    logic signed [GAIN_W-1:0] amp;
    cmd = ($urandom_range(99) < trigger_pct) ? CMD_TRIGGER : CMD_TICK;
    case ($urandom_range(3))
      0:       freq = FREQ_W'($urandom_range(FREQ_MAX));
      1:       freq = FREQ_W'($urandom_range(20000 * 256));
      2:       freq = $urandom_range(1) ? FREQ_MAX : '0;
      default: freq = FREQ_W'($urandom_range(255));
    endcase
    if ($urandom_range(7) == 0) begin
      amp = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    end else begin
      amp = GAIN_W'($urandom_range(16'hFFFF));
    end
    send_item(cmd, freq, amp);
  endtask

  // Receiver: stalls at random or for a requested hold-off, checks transfers
  initial begin
    bank_output_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_outputs.size() == 0) begin
          report_mismatch($sformatf("unexpected output status=%0b sample=%0d",
                                    out_status, out_sample));
        end else begin
          want = pending_outputs.pop_front();
          if (out_status !== want.status) begin
            report_mismatch($sformatf("status %0b, want %0b", out_status, want.status));
          end
          if (out_sample !== want.sample) begin
            report_mismatch($sformatf("sample %0d, want %0d", out_sample, want.sample));
          end
        end
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_empty_tick();
    send_item(CMD_TICK, FREQ_MAX, 16'sh7FFF);
    send_item(CMD_TICK, '0, 16'sh8000);
  endtask

  // Triggers at the reset rate, then ticks over the new voices
  task automatic test_default_rate();
    send_item(CMD_TRIGGER, FREQ_W'(440 * 256), 16'sh7FFF);
    send_item(CMD_TRIGGER, FREQ_MAX, 16'sh8000);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_TICK, '0, '0);
  endtask

  // Zero rate, full-scale rate (wrapped increments), zero frequency and gain
  task automatic test_rate_extremes();
    write_rate('0);
    send_item(CMD_TRIGGER, FREQ_MAX, 16'sh7FFF);
    write_rate(RATE_MAX);
    send_item(CMD_TRIGGER, FREQ_MAX, 16'sh8000);
    send_item(CMD_TRIGGER, '0, 16'sh7FFF);
    send_item(CMD_TRIGGER, FREQ_W'(1), '0);
    send_item(CMD_TRIGGER, FREQ_W'(12345), -16'sd1);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_TICK, '0, '0);
    write_rate(HZ_RESET);
  endtask

  // Random traffic under one idling profile, new rate before each batch
  task automatic test_random_phase(input int send_pct, input int recv_pct);
    logic [HZ_W-1:0] rate;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int b = 0; b < PHASE_ITEMS / BATCH_ITEMS; b++) begin
      case ($urandom_range(3))
        0:       rate = {8'($urandom_range(255)), 32'($urandom)};
        1:       rate = HZ_RESET;
        2:       rate = HZ_W'($urandom_range(32'hFFFF_FFFF));
        default: rate = $urandom_range(1) ? RATE_MAX : '0;
      endcase
      write_rate(rate);
      for (int i = 0; i < BATCH_ITEMS; i++) begin
        send_random_item(TRIGGER_PCT);
      end
    end
    wait_idle();
  endtask

  // Fill the bank if needed, then triggers that find no free voice
  task automatic test_bank_full();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (voices_used < PSOB_VOICES) begin
      send_random_item(100);
    end
    send_item(CMD_TRIGGER, FREQ_MAX, 16'sh7FFF);
    send_item(CMD_TRIGGER, '0, 16'sh8000);
    send_item(CMD_TICK, '0, '0);
    wait_idle();
  endtask

  // Receiver holds off while the sender keeps offering ticks
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = PRESSURE_HOLD;
    for (int i = 0; i < 10; i++) begin
      send_random_item(0);
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < PSOB_SINE_ENTRIES; k++) begin
      sine_lut[k] = sine_point(k);
    end
    rate_model  = HZ_RESET;
    voices_used = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_tick();
    test_default_rate();
    test_rate_extremes();
    test_random_phase(0, 0);
    test_random_phase(78, 0);
    test_random_phase(0, 78);
    test_random_phase(11, 11);
    test_bank_full();
    test_output_backpressure();

    wait_idle();
    repeat (END_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/psob_pkg.sv
rtl/psob_mul.sv
rtl/psob_sine_rom.sv
rtl/psob_voice_ram.sv
rtl/polyphonic_sine_oscillator_bank_core.sv
verif/polyphonic_sine_oscillator_bank_core_tb.sv
